// ===== hdl/dgts_pkg.sv =====
// ----------------------------------------------------------------------------
// dgts_pkg
// Shared types and codes for the dependency graph topological sort core.
// ----------------------------------------------------------------------------
package dgts_pkg;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned FieldKeyWidth = 64;

  // request actions
  localparam logic [ActionWidth-1:0] ACT_ADD_NODE = 3'd0;
  localparam logic [ActionWidth-1:0] ACT_ADD_EDGE = 3'd1;
  localparam logic [ActionWidth-1:0] ACT_CONTAINS = 3'd2;
  localparam logic [ActionWidth-1:0] ACT_DEPS     = 3'd3;
  localparam logic [ActionWidth-1:0] ACT_TOPO     = 3'd4;

  // result status
  localparam logic [StatusWidth-1:0] ST_OK       = 3'd0;
  localparam logic [StatusWidth-1:0] ST_REJECT   = 3'd1;
  localparam logic [StatusWidth-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [StatusWidth-1:0] ST_CYCLE    = 3'd3;
  localparam logic [StatusWidth-1:0] ST_FULL     = 3'd4;

  // walk marks
  localparam logic [1:0] MARK_UNVISITED = 2'd0;
  localparam logic [1:0] MARK_ACTIVE    = 2'd1;
  localparam logic [1:0] MARK_DONE      = 2'd2;

  typedef struct packed {
    logic [ActionWidth-1:0]   action;
    logic [FieldKeyWidth-1:0] asset_key;
    logic [FieldKeyWidth-1:0] dependency_key;
    logic                     source_hash_valid;
  } dgts_req_t;

  typedef struct packed {
    logic [StatusWidth-1:0]   status;
    logic [FieldKeyWidth-1:0] result_key;
    logic                     key_valid;
    logic                     found;
    logic                     last;
  } dgts_rsp_t;

endpackage

// ===== hdl/dgts_ram.sv =====
// ----------------------------------------------------------------------------
// dgts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dgts_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dependency_graph_topo_sort_core.sv =====
// ----------------------------------------------------------------------------
// dependency_graph_topo_sort_core
// Bounded dependency graph with node/edge insert, lookup, dependency listing
// and a depth-first topological order with cycle detection.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | in_req_i  (dgts_req_t)
// out     | output    | out_valid_o/out_ready_i| out_rsp_o (dgts_rsp_t)
//
// Key lookup scans the key RAM linearly, reading then comparing each of the N
// stored nodes, for add node, contains, add edge and dependency listing; add
// edge also scans the node's existing edges. Dependency listing reads each
// edge target, then its key, per result. Topological order clears the marks
// of all N nodes, walks depth-first, then reads each emitted key in order.
// One request is worked on at a time; results leave through an output
// register, and a stalled output only holds the walk at its next result.
// Reset clears the node count; RAM contents need no init.
// ----------------------------------------------------------------------------
module dependency_graph_topo_sort_core #(
  parameter int unsigned MAX_NODES  = 64,
  parameter int unsigned MAX_DEGREE = 8,
  parameter int unsigned KEY_BITS   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dgts_pkg::dgts_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dgts_pkg::dgts_rsp_t out_rsp_o
);

  import dgts_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned DW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned ED  = MAX_NODES * MAX_DEGREE;
  localparam int unsigned EAW = $clog2(ED);
  localparam int unsigned KW  = KEY_BITS;
  localparam int unsigned SW  = IW + DW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SC_RD  = 5'd1;
  localparam logic [4:0] S_SC_CMP = 5'd2;
  localparam logic [4:0] S_DISP   = 5'd3;
  localparam logic [4:0] S_CNT    = 5'd4;
  localparam logic [4:0] S_E_RD   = 5'd5;
  localparam logic [4:0] S_E_CMP  = 5'd6;
  localparam logic [4:0] S_D_RD   = 5'd7;
  localparam logic [4:0] S_D_TGT  = 5'd8;
  localparam logic [4:0] S_D_KEY  = 5'd9;
  localparam logic [4:0] S_CLR    = 5'd10;
  localparam logic [4:0] S_T_ROOT = 5'd11;
  localparam logic [4:0] S_T_RCHK = 5'd12;
  localparam logic [4:0] S_T_TOP  = 5'd13;
  localparam logic [4:0] S_T_EDGE = 5'd14;
  localparam logic [4:0] S_T_MARK = 5'd15;
  localparam logic [4:0] S_T_POP  = 5'd16;
  localparam logic [4:0] S_O_STRT = 5'd17;
  localparam logic [4:0] S_O_RD   = 5'd18;
  localparam logic [4:0] S_O_ORD  = 5'd19;
  localparam logic [4:0] S_O_KEY  = 5'd20;
  localparam logic [4:0] S_EMIT   = 5'd21;

  function automatic dgts_rsp_t mk_rsp(logic [StatusWidth-1:0] st,
                                       logic [FieldKeyWidth-1:0] key,
                                       logic kv, logic fnd, logic lst);
    dgts_rsp_t r;
    r.status     = st;
    r.result_key = key;
    r.key_valid  = kv;
    r.found      = fnd;
    r.last       = lst;
    return r;
  endfunction

  function automatic logic [EAW-1:0] eaddr(logic [IW-1:0] node, logic [DW-1:0] cur);
    return EAW'(node) * EAW'(MAX_DEGREE) + EAW'(cur);
  endfunction

  // control
  logic [4:0]             state_q, state_d, ret_q, ret_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  // working registers
  logic [ActionWidth-1:0] act_q, act_d;
  logic [KW-1:0]          a_q, a_d, d_q, d_d;
  logic                   fa_q, fa_d, fd_q, fd_d;
  logic [IW-1:0]          ia_q, ia_d, id_q, id_d;
  logic [CW-1:0]          idx_q, idx_d, root_q, root_d, depth_q, depth_d, ocnt_q, ocnt_d;
  logic [DW-1:0]          n_q, n_d, j_q, j_d, cur_q, cur_d;
  logic [IW-1:0]          top_q, top_d, next_q, next_d;
  dgts_rsp_t              res_q, res_d, out_q, out_d;

  // RAM ports
  logic            key_we, key_re, etg_we, etg_re, ecn_we, ecn_re;
  logic            mrk_we, mrk_re, stk_we, stk_re, ord_we, ord_re;
  logic [IW-1:0]   key_wa, key_ra, ecn_wa, ecn_ra, mrk_wa, mrk_ra;
  logic [IW-1:0]   stk_wa, stk_ra, ord_wa, ord_ra;
  logic [EAW-1:0]  etg_wa, etg_ra;
  logic [KW-1:0]   key_wd, key_rd;
  logic [IW-1:0]   etg_wd, etg_rd, ord_wd, ord_rd;
  logic [DW-1:0]   ecn_wd, ecn_rd;
  logic [1:0]      mrk_wd, mrk_rd;
  logic [SW-1:0]   stk_wd, stk_rd;

  logic            slot_free;
  logic            lst;
  logic [DW-1:0]   cur_sel;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign cur_sel    = (cur_q == DW'(MAX_DEGREE)) ? '0 : cur_q;

  always_comb begin
    state_d = state_q;  ret_d = ret_q;   cnt_d = cnt_q;
    act_d = act_q;  a_d = a_q;  d_d = d_q;
    fa_d = fa_q;  fd_d = fd_q;  ia_d = ia_q;  id_d = id_q;
    idx_d = idx_q;  root_d = root_q;  depth_d = depth_q;  ocnt_d = ocnt_q;
    n_d = n_q;  j_d = j_q;  cur_d = cur_q;  top_d = top_q;  next_d = next_q;
    res_d = res_q;
    lst = 1'b0;
    key_we = 1'b0; key_wa = '0; key_wd = '0; key_re = 1'b0; key_ra = '0;
    etg_we = 1'b0; etg_wa = '0; etg_wd = '0; etg_re = 1'b0; etg_ra = '0;
    ecn_we = 1'b0; ecn_wa = '0; ecn_wd = '0; ecn_re = 1'b0; ecn_ra = '0;
    mrk_we = 1'b0; mrk_wa = '0; mrk_wd = '0; mrk_re = 1'b0; mrk_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_re = 1'b0; stk_ra = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_re = 1'b0; ord_ra = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_req_i.action;
          a_d   = in_req_i.asset_key[KW-1:0];
          d_d   = in_req_i.dependency_key[KW-1:0];
          fa_d  = 1'b0;
          fd_d  = 1'b0;
          idx_d = '0;
          ret_d = S_IDLE;
          case (in_req_i.action)
            ACT_ADD_NODE: begin
              if (in_req_i.asset_key[KW-1:0] == '0 || !in_req_i.source_hash_valid) begin
                res_d   = mk_rsp(ST_REJECT, '0, 1'b0, 1'b0, 1'b1);
                state_d = S_EMIT;
              end else begin
                state_d = S_SC_RD;
              end
            end
            ACT_ADD_EDGE, ACT_CONTAINS, ACT_DEPS: state_d = S_SC_RD;
            ACT_TOPO: state_d = S_CLR;
            default: begin
              res_d   = mk_rsp(ST_REJECT, '0, 1'b0, 1'b0, 1'b1);
              state_d = S_EMIT;
            end
          endcase
        end
      end

      // linear key scan: read one entry, then compare it against both keys
      S_SC_RD: begin
        if (idx_q == cnt_q) begin
          state_d = S_DISP;
        end else begin
          key_re  = 1'b1;
          key_ra  = idx_q[IW-1:0];
          state_d = S_SC_CMP;
        end
      end

      S_SC_CMP: begin
        if (key_rd == a_q) begin
          fa_d = 1'b1;
          ia_d = idx_q[IW-1:0];
        end
        if (key_rd == d_q) begin
          fd_d = 1'b1;
          id_d = idx_q[IW-1:0];
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_SC_RD;
      end

      S_DISP: begin
        state_d = S_EMIT;
        case (act_q)
          ACT_ADD_NODE: begin
            if (fa_q) begin
              res_d = mk_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
            end else if (cnt_q == CW'(MAX_NODES)) begin
              res_d = mk_rsp(ST_FULL, '0, 1'b0, 1'b0, 1'b1);
            end else begin
              key_we = 1'b1;
              key_wa = cnt_q[IW-1:0];
              key_wd = a_q;
              ecn_we = 1'b1;
              ecn_wa = cnt_q[IW-1:0];
              ecn_wd = '0;
              cnt_d  = cnt_q + 1'b1;
              res_d  = mk_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
            end
          end
          ACT_ADD_EDGE: begin
            if (a_q == d_q || !fa_q || !fd_q) begin
              res_d = mk_rsp(ST_REJECT, '0, 1'b0, 1'b0, 1'b1);
            end else begin
              ecn_re  = 1'b1;
              ecn_ra  = ia_q;
              state_d = S_CNT;
            end
          end
          ACT_CONTAINS: res_d = mk_rsp(ST_OK, '0, 1'b0, fa_q, 1'b1);
          ACT_DEPS: begin
            if (!fa_q) begin
              res_d = mk_rsp(ST_NOTFOUND, '0, 1'b0, 1'b0, 1'b1);
            end else begin
              ecn_re  = 1'b1;
              ecn_ra  = ia_q;
              state_d = S_CNT;
            end
          end
          default: res_d = mk_rsp(ST_REJECT, '0, 1'b0, 1'b0, 1'b1);
        endcase
      end

      S_CNT: begin
        n_d = ecn_rd;
        j_d = '0;
        if (act_q == ACT_ADD_EDGE) begin
          state_d = S_E_RD;
        end else if (ecn_rd == '0) begin
          res_d   = mk_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
          state_d = S_EMIT;
        end else begin
          state_d = S_D_RD;
        end
      end

      S_E_RD: begin
        if (j_q == n_q) begin
          state_d = S_EMIT;
          if (n_q == DW'(MAX_DEGREE)) begin
            res_d = mk_rsp(ST_FULL, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            etg_we = 1'b1;
            etg_wa = eaddr(ia_q, n_q);
            etg_wd = id_q;
            ecn_we = 1'b1;
            ecn_wa = ia_q;
            ecn_wd = n_q + 1'b1;
            res_d  = mk_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
          end
        end else begin
          etg_re  = 1'b1;
          etg_ra  = eaddr(ia_q, j_q);
          state_d = S_E_CMP;
        end
      end

      S_E_CMP: begin
        if (etg_rd == id_q) begin
          res_d   = mk_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
          state_d = S_EMIT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_E_RD;
        end
      end

      S_D_RD: begin
        etg_re  = 1'b1;
        etg_ra  = eaddr(ia_q, j_q);
        state_d = S_D_TGT;
      end

      S_D_TGT: begin
        key_re  = 1'b1;
        key_ra  = etg_rd;
        state_d = S_D_KEY;
      end

      S_D_KEY: begin
        lst     = (j_q + 1'b1 == n_q);
        res_d   = mk_rsp(ST_OK, FieldKeyWidth'(key_rd), 1'b1, 1'b0, lst);
        j_d     = j_q + 1'b1;
        ret_d   = lst ? S_IDLE : S_D_RD;
        state_d = S_EMIT;
      end

      // clear marks of all live nodes before the walk
      S_CLR: begin
        if (idx_q == cnt_q) begin
          root_d  = '0;
          ocnt_d  = '0;
          state_d = S_T_ROOT;
        end else begin
          mrk_we = 1'b1;
          mrk_wa = idx_q[IW-1:0];
          mrk_wd = MARK_UNVISITED;
          idx_d  = idx_q + 1'b1;
        end
      end

      S_T_ROOT: begin
        if (root_q == cnt_q) begin
          state_d = S_O_STRT;
        end else begin
          mrk_re  = 1'b1;
          mrk_ra  = root_q[IW-1:0];
          state_d = S_T_RCHK;
        end
      end

      S_T_RCHK: begin
        if (mrk_rd != MARK_UNVISITED) begin
          root_d  = root_q + 1'b1;
          state_d = S_T_ROOT;
        end else begin
          mrk_we  = 1'b1;
          mrk_wa  = root_q[IW-1:0];
          mrk_wd  = MARK_ACTIVE;
          top_d   = root_q[IW-1:0];
          cur_d   = '0;
          depth_d = CW'(1);
          state_d = S_T_TOP;
        end
      end

      // top of stack lives in top_q/cur_q; RAM holds the entries below it
      S_T_TOP: begin
        ecn_re  = 1'b1;
        ecn_ra  = top_q;
        etg_re  = 1'b1;
        etg_ra  = eaddr(top_q, cur_sel);
        state_d = S_T_EDGE;
      end

      S_T_EDGE: begin
        if (cur_q < ecn_rd) begin
          next_d  = etg_rd;
          cur_d   = cur_q + 1'b1;
          mrk_re  = 1'b1;
          mrk_ra  = etg_rd;
          state_d = S_T_MARK;
        end else begin
          mrk_we  = 1'b1;
          mrk_wa  = top_q;
          mrk_wd  = MARK_DONE;
          ord_we  = 1'b1;
          ord_wa  = ocnt_q[IW-1:0];
          ord_wd  = top_q;
          ocnt_d  = ocnt_q + 1'b1;
          depth_d = depth_q - 1'b1;
          if (depth_q == CW'(1)) begin
            root_d  = root_q + 1'b1;
            state_d = S_T_ROOT;
          end else begin
            stk_re  = 1'b1;
            stk_ra  = IW'(depth_q - CW'(2));
            state_d = S_T_POP;
          end
        end
      end

      S_T_MARK: begin
        if (mrk_rd == MARK_ACTIVE) begin
          res_d   = mk_rsp(ST_CYCLE, '0, 1'b0, 1'b0, 1'b1);
          state_d = S_EMIT;
        end else if (mrk_rd == MARK_UNVISITED) begin
          mrk_we  = 1'b1;
          mrk_wa  = next_q;
          mrk_wd  = MARK_ACTIVE;
          stk_we  = 1'b1;
          stk_wa  = IW'(depth_q - CW'(1));
          stk_wd  = {top_q, cur_q};
          top_d   = next_q;
          cur_d   = '0;
          depth_d = depth_q + 1'b1;
          state_d = S_T_TOP;
        end else begin
          state_d = S_T_TOP;
        end
      end

      S_T_POP: begin
        top_d   = stk_rd[SW-1:DW];
        cur_d   = stk_rd[DW-1:0];
        state_d = S_T_TOP;
      end

      S_O_STRT: begin
        if (ocnt_q == '0) begin
          res_d   = mk_rsp(ST_OK, '0, 1'b0, 1'b0, 1'b1);
          state_d = S_EMIT;
        end else begin
          idx_d   = '0;
          state_d = S_O_RD;
        end
      end

      S_O_RD: begin
        ord_re  = 1'b1;
        ord_ra  = idx_q[IW-1:0];
        state_d = S_O_ORD;
      end

      S_O_ORD: begin
        key_re  = 1'b1;
        key_ra  = ord_rd;
        state_d = S_O_KEY;
      end

      S_O_KEY: begin
        lst     = (idx_q + 1'b1 == ocnt_q);
        res_d   = mk_rsp(ST_OK, FieldKeyWidth'(key_rd), 1'b1, 1'b0, lst);
        idx_d   = idx_q + 1'b1;
        ret_d   = lst ? S_IDLE : S_O_RD;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          state_d = ret_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (state_q == S_EMIT && slot_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    a_q     <= a_d;
    d_q     <= d_d;
    fa_q    <= fa_d;
    fd_q    <= fd_d;
    ia_q    <= ia_d;
    id_q    <= id_d;
    idx_q   <= idx_d;
    root_q  <= root_d;
    depth_q <= depth_d;
    ocnt_q  <= ocnt_d;
    n_q     <= n_d;
    j_q     <= j_d;
    cur_q   <= cur_d;
    top_q   <= top_d;
    next_q  <= next_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  dgts_ram #(.DEPTH(MAX_NODES), .WIDTH(KW)) u_keys (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_wd),
    .re_i(key_re), .raddr_i(key_ra), .rdata_o(key_rd)
  );

  dgts_ram #(.DEPTH(ED), .WIDTH(IW)) u_edges (
    .clk_i, .we_i(etg_we), .waddr_i(etg_wa), .wdata_i(etg_wd),
    .re_i(etg_re), .raddr_i(etg_ra), .rdata_o(etg_rd)
  );

  dgts_ram #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_degree (
    .clk_i, .we_i(ecn_we), .waddr_i(ecn_wa), .wdata_i(ecn_wd),
    .re_i(ecn_re), .raddr_i(ecn_ra), .rdata_o(ecn_rd)
  );

  dgts_ram #(.DEPTH(MAX_NODES), .WIDTH(2)) u_marks (
    .clk_i, .we_i(mrk_we), .waddr_i(mrk_wa), .wdata_i(mrk_wd),
    .re_i(mrk_re), .raddr_i(mrk_ra), .rdata_o(mrk_rd)
  );

  dgts_ram #(.DEPTH(MAX_NODES), .WIDTH(SW)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .re_i(stk_re), .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  dgts_ram #(.DEPTH(MAX_NODES), .WIDTH(IW)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .re_i(ord_re), .raddr_i(ord_ra), .rdata_o(ord_rd)
  );

endmodule

// ===== hdl/dgts_checker.sv =====
// ----------------------------------------------------------------------------
// dgts_checker
// Port-level checks for the topological sort core, bound to the top level.
// ----------------------------------------------------------------------------
module dgts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input dgts_pkg::dgts_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dgts_pkg::dgts_rsp_t out_rsp_o
);

  import dgts_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == ST_OK || out_rsp_o.status == ST_REJECT ||
                     out_rsp_o.status == ST_NOTFOUND || out_rsp_o.status == ST_CYCLE ||
                     out_rsp_o.status == ST_FULL))
    else $error("bad status");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.key_valid |-> out_rsp_o.result_key == '0)
    else $error("key without key_valid");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |-> !out_rsp_o.key_valid && out_rsp_o.last &&
                                        out_rsp_o.status == ST_OK)
    else $error("found on wrong result");

endmodule

bind dependency_graph_topo_sort_core dgts_checker u_dgts_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o),
  .in_req_i(in_req_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o(out_rsp_o)
);

// ===== bench/dependency_graph_topo_sort_core_tb.sv =====
// ----------------------------------------------------------------------------
// dependency_graph_topo_sort_core_tb
// Drives graph requests (node/edge insert, lookup, dependency listing and
// topological order) with random gaps and output stalls, predicts each
// result from a behavioral graph model and compares result by result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dependency_graph_topo_sort_core_tb;
  import dgts_pkg::*;

  localparam int unsigned NodeMax  = 64;
  localparam int unsigned DegMax   = 8;
  localparam int unsigned CycLimit = 2000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  dgts_req_t in_req_i;
  logic      out_valid_o;
  logic      out_ready_i;
  dgts_rsp_t out_rsp_o;

  dependency_graph_topo_sort_core #(
    .MAX_NODES(NodeMax), .MAX_DEGREE(DegMax), .KEY_BITS(64)
  ) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_rsp_o(out_rsp_o)
  );

  // graph model state
  logic [63:0] g_keys [NodeMax];
  int          g_count;
  int          g_edges [NodeMax][DegMax];
  int          g_deg [NodeMax];

  dgts_rsp_t   rsp_queue[$];
  int          errors;
  int          cycles;
  bit          calm;
  bit          hold_rx;
  bit          drv_on;
  logic [63:0] key_pool[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int find_node(logic [63:0] k);
    if (k == 64'd0) return -1;
    for (int i = 0; i < g_count; i++) if (g_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic dgts_rsp_t mk(logic [2:0] st, logic [63:0] k, bit kv, bit f, bit l);
    dgts_rsp_t r;
    r.status = st; r.result_key = k; r.key_valid = kv; r.found = f; r.last = l;
    return r;
  endfunction

  // append one expected result
  function automatic void exp_add(dgts_rsp_t r);
    rsp_queue = {rsp_queue, r};
  endfunction

  task automatic predict_topo();
    int mark [NodeMax];
    int stk_n [NodeMax];
    int stk_c [NodeMax];
    int order[$];
    int sp, nd, nx;
    for (int i = 0; i < NodeMax; i++) mark[i] = 0;
    for (int r = 0; r < g_count; r++) begin
      if (mark[r] != 0) continue;
      mark[r] = 1; stk_n[0] = r; stk_c[0] = 0; sp = 1;
      while (sp > 0) begin
        nd = stk_n[sp-1];
        if (stk_c[sp-1] < g_deg[nd]) begin
          nx = g_edges[nd][stk_c[sp-1]];
          stk_c[sp-1]++;
          if (mark[nx] == 1) begin
            exp_add(mk(ST_CYCLE, 64'd0, 0, 0, 1));
            return;
          end
          if (mark[nx] == 0 && sp < NodeMax) begin
            mark[nx] = 1; stk_n[sp] = nx; stk_c[sp] = 0; sp++;
          end
        end else begin
          mark[nd] = 2; order = {order, nd}; sp--;
        end
      end
    end
    if (order.size() == 0) exp_add(mk(ST_OK, 64'd0, 0, 0, 1));
    foreach (order[i])
      exp_add(mk(ST_OK, g_keys[order[i]], 1, 0, i == order.size() - 1));
  endtask

  task automatic predict_graph(dgts_req_t q);
    int ia, id, n;
    bit dup;
    case (q.action)
      ACT_ADD_NODE: begin
        if (q.asset_key == 0 || !q.source_hash_valid)
          exp_add(mk(ST_REJECT, 0, 0, 0, 1));
        else if (find_node(q.asset_key) >= 0)
          exp_add(mk(ST_OK, 0, 0, 0, 1));
        else if (g_count >= NodeMax)
          exp_add(mk(ST_FULL, 0, 0, 0, 1));
        else begin
          g_keys[g_count] = q.asset_key; g_deg[g_count] = 0; g_count++;
          exp_add(mk(ST_OK, 0, 0, 0, 1));
        end
      end
      ACT_ADD_EDGE: begin
        ia = find_node(q.asset_key);
        id = find_node(q.dependency_key);
        if (q.asset_key == q.dependency_key || ia < 0 || id < 0)
          exp_add(mk(ST_REJECT, 0, 0, 0, 1));
        else begin
          dup = 0;
          for (int i = 0; i < g_deg[ia]; i++) if (g_edges[ia][i] == id) dup = 1;
          if (dup) exp_add(mk(ST_OK, 0, 0, 0, 1));
          else if (g_deg[ia] >= DegMax) exp_add(mk(ST_FULL, 0, 0, 0, 1));
          else begin
            g_edges[ia][g_deg[ia]] = id; g_deg[ia]++;
            exp_add(mk(ST_OK, 0, 0, 0, 1));
          end
        end
      end
      ACT_CONTAINS:
        exp_add(mk(ST_OK, 0, 0, find_node(q.asset_key) >= 0, 1));
      ACT_DEPS: begin
        ia = find_node(q.asset_key);
        if (ia < 0) exp_add(mk(ST_NOTFOUND, 0, 0, 0, 1));
        else begin
          n = g_deg[ia];
          if (n == 0) exp_add(mk(ST_OK, 0, 0, 0, 1));
          for (int i = 0; i < n; i++)
            exp_add(mk(ST_OK, g_keys[g_edges[ia][i]], 1, 0, i == n - 1));
        end
      end
      ACT_TOPO: predict_topo();
      default: exp_add(mk(ST_REJECT, 0, 0, 0, 1));
    endcase
  endtask

  // drop valid once the last request has been taken
  task automatic idle_in();
    if (drv_on) begin
      in_valid_i <= 1'b0;
      drv_on = 1'b0;
    end
  endtask

  // one request, with an optional random gap ahead of it; valid stays up
  // so the next request can follow without a drop in valid
  task automatic send_req(logic [2:0] act, logic [63:0] ak, logic [63:0] dk, bit hv);
    dgts_req_t q;
    if (!calm && $urandom_range(0, 3) == 0) begin
      idle_in();
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    q.action = act; q.asset_key = ak; q.dependency_key = dk; q.source_hash_valid = hv;
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    drv_on = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_graph(q);
  endtask

  task automatic wait_drain();
    idle_in();
    while (rsp_queue.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // receiver stalls
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    dgts_rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_rsp_o);
      end else begin
        e = rsp_queue.pop_front();
        if (out_rsp_o.status !== e.status)
          $display("%0t: status exp %0d act %0d", $time, e.status, out_rsp_o.status);
        if (out_rsp_o.result_key !== e.result_key)
          $display("%0t: result_key exp %h act %h", $time, e.result_key, out_rsp_o.result_key);
        if (out_rsp_o.key_valid !== e.key_valid)
          $display("%0t: key_valid exp %b act %b", $time, e.key_valid, out_rsp_o.key_valid);
        if (out_rsp_o.found !== e.found)
          $display("%0t: found exp %b act %b", $time, e.found, out_rsp_o.found);
        if (out_rsp_o.last !== e.last)
          $display("%0t: last exp %b act %b", $time, e.last, out_rsp_o.last);
        if (out_rsp_o !== e) errors++;
      end
    end
  end

  function automatic logic [63:0] rnd_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) return rnd_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic test_directed();
    send_req(ACT_TOPO, 0, 0, 1);                    // empty graph
    send_req(ACT_ADD_NODE, 0, 0, 1);                // zero key
    send_req(ACT_ADD_NODE, 64'h11, 0, 0);           // bad hash
    send_req(ACT_ADD_NODE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1);
    send_req(ACT_ADD_NODE, 64'h1, 0, 1);
    send_req(ACT_ADD_NODE, 64'h1, 0, 1);            // known key again
    send_req(ACT_ADD_NODE, 64'h5555_AAAA_5555_AAAA, 0, 1);
    send_req(ACT_CONTAINS, 64'h1, 0, 0);
    send_req(ACT_CONTAINS, 64'h2, 0, 0);
    send_req(ACT_CONTAINS, 0, 0, 0);
    send_req(ACT_ADD_EDGE, 64'h1, 64'h1, 1);        // self-loop
    send_req(ACT_ADD_EDGE, 64'h1, 64'h9, 1);        // unknown dependency
    send_req(ACT_ADD_EDGE, 0, 64'h1, 1);
    send_req(ACT_ADD_EDGE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1);
    send_req(ACT_ADD_EDGE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1); // duplicate
    send_req(ACT_ADD_EDGE, 64'h1, 64'h5555_AAAA_5555_AAAA, 0);
    send_req(ACT_DEPS, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1);
    send_req(ACT_DEPS, 64'h5555_AAAA_5555_AAAA, 0, 1); // no edges
    send_req(ACT_DEPS, 64'h77, 0, 1);               // not found
    send_req(ACT_TOPO, 0, 0, 0);
    send_req(ACT_ADD_EDGE, 64'h5555_AAAA_5555_AAAA, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_req(ACT_TOPO, 0, 0, 0);                    // cycle
    send_req(3'd5, 64'h1, 0, 1);
    send_req(3'd7, 64'h1, 0, 1);
    wait_drain();
  endtask

  // fill the table to capacity and one node's degree to its limit
  task automatic test_capacity();
    for (int i = 0; g_count < NodeMax; i++) begin
      send_req(ACT_ADD_NODE, 64'h100 + i, 0, 1);
      key_pool = {key_pool, 64'h100 + i};
    end
    send_req(ACT_ADD_NODE, 64'hDEAD, 0, 1);          // full table
    for (int i = 1; i <= DegMax + 1; i++)
      send_req(ACT_ADD_EDGE, 64'h100, 64'h100 + i, 1);
    send_req(ACT_DEPS, 64'h100, 0, 1);
    wait_drain();
  endtask

  // output held off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1;
        repeat (300) @(posedge clk_i);
        hold_rx = 0;
      end
      begin
        send_req(ACT_TOPO, 0, 0, 1);
        for (int i = 0; i < 6; i++) send_req(ACT_CONTAINS, pick_key(), 0, 1);
        idle_in();
      end
    join
    wait_drain();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_req(ACT_ADD_EDGE, pick_key(), pick_key(), 1'($urandom_range(0, 1)));
      else if (r < 72) send_req(ACT_ADD_NODE, pick_key(), 0, 1'($urandom_range(0, 1)));
      else if (r < 80)
        send_req(ACT_CONTAINS, pick_key(), rnd_key(), 1'($urandom_range(0, 1)));
      else if (r < 90) send_req(ACT_DEPS, pick_key(), rnd_key(), 1'($urandom_range(0, 1)));
      else if (r < 97) send_req(ACT_TOPO, rnd_key(), rnd_key(), 1'($urandom_range(0, 1)));
      else send_req(3'($urandom_range(5, 7)), rnd_key(), rnd_key(),
                    1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    errors = 0; g_count = 0; calm = 0; hold_rx = 0; drv_on = 0;
    for (int i = 0; i < NodeMax; i++) g_deg[i] = 0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    rst_ni     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random(30);
    calm = 1;
    test_random(20);
    wait_drain();
    if (errors == 0 && rsp_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dgts_pkg.sv
hdl/dgts_ram.sv
hdl/dependency_graph_topo_sort_core.sv
hdl/dgts_checker.sv
bench/dependency_graph_topo_sort_core_tb.sv
